@@ hw/rtl/hsv2rgb_pkg.sv @@
// Package for the HSV to RGB converter: widths, fixed-point constants,
// sector and component-select codes, and the operand struct.
// No dependencies.
package hsv2rgb_pkg;

   // Field widths
   localparam int HUE_W = 16;
   localparam int SV_W  = 13;
   localparam int LVL_W = 11;

   // Q1.12 unity for saturation and value
   localparam logic [SV_W-1:0] Q_ONE = 13'd4096;

   // Hue reduction: 5760 = 45 * 128, so the low 7 bits pass straight through
   localparam int CHUNK_SHIFT = 7;
   localparam int CHUNK_W     = HUE_W - CHUNK_SHIFT;
   localparam logic [CHUNK_W-1:0] CHUNK_MOD = 9'd45;
   localparam int RECIP45_W     = 11;
   localparam int RECIP45_SHIFT = 16;
   localparam logic [RECIP45_W-1:0] RECIP45 = 11'd1456;   // floor(2^16 / 45)
   localparam int CHUNK_Q_W = CHUNK_W + RECIP45_W - RECIP45_SHIFT;
   localparam int HR_W      = 13;                          // reduced hue < 5760

   // Sector geometry in sixteenths of a degree
   localparam int W_W  = 10;
   localparam int T_W  = 11;
   localparam logic [W_W-1:0]  HUE_SEC  = 10'd960;
   localparam logic [T_W-1:0]  HUE_SPAN = 11'd1920;
   localparam logic [HR_W-1:0] SEC_B1 = 13'd960;
   localparam logic [HR_W-1:0] SEC_B2 = 13'd1920;
   localparam logic [HR_W-1:0] SEC_B3 = 13'd2880;
   localparam logic [HR_W-1:0] SEC_B4 = 13'd3840;
   localparam logic [HR_W-1:0] SEC_B5 = 13'd4800;

   // Chroma, offset and channel sum widths
   localparam int C_W   = 25;      // up to 2^24
   localparam int NUM_W = 34;      // up to 960 * 2^24

   // Output scaling: level = floor(num * scale / (15 * 2^30))
   localparam int SCALE_W = 16;
   localparam logic [SCALE_W-1:0] OUT_FULL_SCALE = 16'd2047;
   localparam int LEVEL_SHIFT = 30;
   localparam int PROD_W = NUM_W + SCALE_W;
   localparam int Y_W    = PROD_W - LEVEL_SHIFT;
   localparam int RECIP15_W     = 19;
   localparam int RECIP15_SHIFT = 22;
   localparam logic [RECIP15_W-1:0] RECIP15 = 19'd279620;  // floor(2^22 / 15)
   localparam int Q0_W = Y_W + RECIP15_W - RECIP15_SHIFT;
   localparam logic [Y_W-1:0] DIV15 = 20'd15;

   // Latency from accepted beat to result strobe
   localparam int PIPE_DEPTH = 7;

   // 60-degree sectors of the colour wheel
   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   // Which term a channel adds to the offset
   typedef enum logic [1:0] {
      COMP_ZERO   = 2'd0,
      COMP_CHROMA = 2'd1,
      COMP_MID    = 2'd2
   } comp_sel_type;

   // Operands shared by all three channel pipes
   typedef struct packed {
      logic [C_W-1:0]   m;   // offset v - c, Q1.24
      logic [C_W-1:0]   c;   // chroma, Q1.24
      logic [NUM_W-1:0] k;   // c * w, intermediate in 1/960 units
   } chan_opnd_type;

endpackage

@@ hw/rtl/hsv_to_rgb_11bit.sv @@
// HSV colour in, three 11-bit PWM levels out, as a seven-stage pipeline.
// The result of a beat accepted on start appears on rsp_valid and the rsp_ level ports
// for one cycle, once it has passed through all the stages; a new beat may be accepted every
// cycle, and busy stays low since the pipeline never stalls. The receiver
// cannot hold results off. The latency is set by the chain of multipliers:
// hue reduction, chroma, the intermediate term, output scaling and the
// reciprocal divide by 15.
// Depends on hsv2rgb_pkg and hsv2rgb_level.
module hsv_to_rgb_11bit import hsv2rgb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [HUE_W-1:0] req_hue,
   input  logic [SV_W-1:0]  req_saturation,
   input  logic [SV_W-1:0]  req_brightness,
   output logic             rsp_valid,
   output logic [LVL_W-1:0] rsp_red,
   output logic [LVL_W-1:0] rsp_green,
   output logic [LVL_W-1:0] rsp_blue
);

   logic [PIPE_DEPTH-1:0]  valid_ff, valid_in;

   // Stage 1 registers
   logic [HR_W-1:0]        hr_ff, hr_in;
   logic [SV_W-1:0]        sat_ff, sat_in;
   logic [SV_W-1:0]        val_ff, val_in;
   // Stage 2 registers
   logic [C_W-1:0]         c_ff, c_in;
   logic [SV_W-1:0]        v2_ff;
   sector_type             sector_ff, sector_in;
   logic [W_W-1:0]         w_ff, w_in;
   // Stage 3 registers
   chan_opnd_type          opnd_ff, opnd_in;
   comp_sel_type           sel_r_ff, sel_r_in;
   comp_sel_type           sel_g_ff, sel_g_in;
   comp_sel_type           sel_b_ff, sel_b_in;

   logic [CHUNK_W-1:0]            chunk;
   logic [CHUNK_W+RECIP45_W-1:0]  chunk_prod;
   logic [CHUNK_Q_W-1:0]          chunk_q;
   logic [CHUNK_W-1:0]            chunk_rem0;
   logic [CHUNK_W-1:0]            chunk_rem;
   logic [T_W-1:0]                span_base;
   logic [HR_W-1:0]               t_full;
   logic [T_W-1:0]                t;
   logic [T_W-1:0]                w_full;
   logic [2*SV_W-1:0]             vs_prod;
   logic [C_W+W_W-1:0]            k_full;

   // Never stalls
   assign busy = 1'b0;

   // Valid bits travel alongside the data
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: clamp s and v, reduce hue modulo 5760 via hue[15:7] mod 45
   always_comb begin
      sat_in     = (req_saturation > Q_ONE) ? Q_ONE : req_saturation;
      val_in     = (req_brightness > Q_ONE) ? Q_ONE : req_brightness;
      chunk      = req_hue[HUE_W-1:CHUNK_SHIFT];
      chunk_prod = (CHUNK_W+RECIP45_W)'(chunk) * (CHUNK_W+RECIP45_W)'(RECIP45);
      chunk_q    = chunk_prod[CHUNK_W+RECIP45_W-1:RECIP45_SHIFT];
      chunk_rem0 = chunk - CHUNK_W'(chunk_q) * CHUNK_MOD;
      chunk_rem  = (chunk_rem0 >= CHUNK_MOD) ? chunk_rem0 - CHUNK_MOD : chunk_rem0;
      hr_in      = {chunk_rem[HR_W-CHUNK_SHIFT-1:0], req_hue[CHUNK_SHIFT-1:0]};
   end

   // Stage 2: chroma, sector and distance into the 120-degree span
   always_comb begin
      vs_prod = sat_ff * val_ff;
      c_in    = vs_prod[C_W-1:0];
      priority if (hr_ff >= SEC_B5) sector_in = SEC_MAGENTA;
      else if (hr_ff >= SEC_B4)     sector_in = SEC_BLUE;
      else if (hr_ff >= SEC_B3)     sector_in = SEC_CYAN;
      else if (hr_ff >= SEC_B2)     sector_in = SEC_GREEN;
      else if (hr_ff >= SEC_B1)     sector_in = SEC_YELLOW;
      else                          sector_in = SEC_RED;
      priority if (hr_ff >= SEC_B4) span_base = SEC_B4[T_W-1:0];
      else if (hr_ff >= SEC_B2)     span_base = SEC_B2[T_W-1:0];
      else                          span_base = '0;
      t_full = hr_ff - HR_W'(span_base);
      t      = t_full[T_W-1:0];
      w_full = (t >= T_W'(HUE_SEC)) ? HUE_SPAN - t : t;
      w_in   = w_full[W_W-1:0];
   end

   // Stage 3: offset, intermediate term and per-channel selection
   always_comb begin
      k_full    = c_ff * w_ff;
      opnd_in.c = c_ff;
      opnd_in.m = (C_W'(v2_ff) << (SV_W - 1)) - c_ff;
      opnd_in.k = k_full[NUM_W-1:0];
      unique case (sector_ff)
         SEC_RED: begin
            sel_r_in = COMP_CHROMA; sel_g_in = COMP_MID;    sel_b_in = COMP_ZERO;
         end
         SEC_YELLOW: begin
            sel_r_in = COMP_MID;    sel_g_in = COMP_CHROMA; sel_b_in = COMP_ZERO;
         end
         SEC_GREEN: begin
            sel_r_in = COMP_ZERO;   sel_g_in = COMP_CHROMA; sel_b_in = COMP_MID;
         end
         SEC_CYAN: begin
            sel_r_in = COMP_ZERO;   sel_g_in = COMP_MID;    sel_b_in = COMP_CHROMA;
         end
         SEC_BLUE: begin
            sel_r_in = COMP_MID;    sel_g_in = COMP_ZERO;   sel_b_in = COMP_CHROMA;
         end
         default: begin
            sel_r_in = COMP_CHROMA; sel_g_in = COMP_ZERO;   sel_b_in = COMP_MID;
         end
      endcase
   end

   // Payload registers of the first three stages
   always_ff @(posedge clock) begin
      hr_ff     <= hr_in;
      sat_ff    <= sat_in;
      val_ff    <= val_in;
      c_ff      <= c_in;
      v2_ff     <= val_ff;
      sector_ff <= sector_in;
      w_ff      <= w_in;
      opnd_ff   <= opnd_in;
      sel_r_ff  <= sel_r_in;
      sel_g_ff  <= sel_g_in;
      sel_b_ff  <= sel_b_in;
   end

   // Stages 4 to 7, one pipe per channel
   hsv2rgb_level u_red (
      .clock (clock),
      .opnd  (opnd_ff),
      .sel   (sel_r_ff),
      .level (rsp_red)
   );

   hsv2rgb_level u_green (
      .clock (clock),
      .opnd  (opnd_ff),
      .sel   (sel_g_ff),
      .level (rsp_green)
   );

   hsv2rgb_level u_blue (
      .clock (clock),
      .opnd  (opnd_ff),
      .sel   (sel_b_ff),
      .level (rsp_blue)
   );

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   // Every accepted beat gives a result after the pipeline latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("result strobe missing after accepted beat");

   // Zero brightness is black
   a_black: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_brightness == '0) |-> ##PIPE_DEPTH
         (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0))
      else $error("zero brightness did not give black");

   // Zero saturation is grey
   a_grey: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_saturation == '0) |-> ##PIPE_DEPTH
         (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("zero saturation did not give grey");

endmodule

@@ hw/rtl/hsv2rgb_level.sv @@
// One colour channel: forms the channel sum, scales it and divides by the
// sector width to give the PWM level. Four register stages.
// Depends on hsv2rgb_pkg.
module hsv2rgb_level import hsv2rgb_pkg::*; (
   input  logic             clock,
   input  chan_opnd_type    opnd,
   input  comp_sel_type     sel,
   output logic [LVL_W-1:0] level
);

   logic [NUM_W-1:0]       num_ff, num_in;
   logic [Y_W-1:0]         y_ff, y_in;
   logic [Y_W-1:0]         y2_ff;
   logic [Q0_W-1:0]        q0_ff, q0_in;
   logic [LVL_W-1:0]       level_ff, level_in;

   logic [C_W+W_W-1:0]     m_scaled;
   logic [C_W+W_W-1:0]     c_scaled;
   logic [NUM_W-1:0]       comp;
   logic [PROD_W-1:0]      prod;
   logic [Y_W+RECIP15_W-1:0] qprod;
   logic [Y_W-1:0]         q15;
   logic [Y_W-1:0]         rem;
   logic [Q0_W-1:0]        quot;

   // Channel sum: 960*m plus the selected term
   always_comb begin
      m_scaled = opnd.m * C_W'(HUE_SEC);
      c_scaled = opnd.c * C_W'(HUE_SEC);
      unique case (sel)
         COMP_CHROMA: comp = c_scaled[NUM_W-1:0];
         COMP_MID:    comp = opnd.k;
         COMP_ZERO:   comp = '0;
         default:     comp = '0;
      endcase
      num_in = m_scaled[NUM_W-1:0] + comp;
   end

   // Scale and drop the power-of-two part of the divisor
   always_comb begin
      prod = PROD_W'(num_ff) * PROD_W'(OUT_FULL_SCALE);
      y_in = prod[PROD_W-1:LEVEL_SHIFT];
   end

   // Estimate y / 15 by reciprocal; low by at most one
   always_comb begin
      qprod = (Y_W+RECIP15_W)'(y_ff) * (Y_W+RECIP15_W)'(RECIP15);
      q0_in = qprod[Y_W+RECIP15_W-1:RECIP15_SHIFT];
   end

   // One correction step
   always_comb begin
      q15      = Y_W'(q0_ff) * DIV15;
      rem      = y2_ff - q15;
      quot     = (rem >= DIV15) ? q0_ff + Q0_W'(1) : q0_ff;
      level_in = quot[LVL_W-1:0];
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      y_ff     <= y_in;
      y2_ff    <= y_ff;
      q0_ff    <= q0_in;
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_rgb_11bit: drives HSV beats on the
// start/busy handshake and compares each rsp_ strobe with a built-in predictor.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_11bit RTL.
module testbench import hsv2rgb_pkg::*; ;

   // Predictor constants, all 64-bit so that no product overflows
   localparam logic [63:0] UNITY       = 64'd4096;
   localparam logic [63:0] HUE_TURN    = 64'd5760;
   localparam logic [63:0] SECTOR_SPAN = 64'd960;
   localparam logic [63:0] FULL_SCALE  = 64'd2047;
   localparam logic [63:0] LEVEL_DEN   = 64'd16106127360;   // 2^24 * 960
   localparam int          STALL_LIMIT = 4000;
   localparam int          REPORT_MAX  = 10;

   typedef struct packed {
      logic [LVL_W-1:0] red;
      logic [LVL_W-1:0] green;
      logic [LVL_W-1:0] blue;
   } rgb_levels_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [HUE_W-1:0] req_hue;
   logic [SV_W-1:0]  req_saturation;
   logic [SV_W-1:0]  req_brightness;
   logic             rsp_valid;
   logic [LVL_W-1:0] rsp_red;
   logic [LVL_W-1:0] rsp_green;
   logic [LVL_W-1:0] rsp_blue;

   rgb_levels_type expected_levels[$];
   int             fail_count = 0;
   int             quiet_cycles = 0;
   int             sender_idle_pct;

   hsv_to_rgb_11bit u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Scale a channel sum held in 1/(2^24*960) units to an 11-bit level
   function automatic logic [LVL_W-1:0] scale_level(input logic [63:0] num);
      logic [63:0] lvl;
      lvl = (num * FULL_SCALE) / LEVEL_DEN;
      return lvl[LVL_W-1:0];
   endfunction

   // Exact fixed-point HSV to RGB conversion
   function automatic rgb_levels_type predict_rgb(input logic [HUE_W-1:0] hue,
                                                  input logic [SV_W-1:0]  sat,
                                                  input logic [SV_W-1:0]  val);
      logic [63:0] s, v, hr, t, w, chroma, c_num, x_num, m_num;
      logic [63:0] r_num, g_num, b_num;
      sector_type  sector;
      rgb_levels_type lv;
      s = (sat > UNITY) ? UNITY : 64'(sat);
      v = (val > UNITY) ? UNITY : 64'(val);
      hr = 64'(hue) % HUE_TURN;
      sector = sector_type'(3'(hr / SECTOR_SPAN));
      t = hr % (2 * SECTOR_SPAN);
      w = (t >= SECTOR_SPAN) ? (2 * SECTOR_SPAN - t) : t;
      chroma = v * s;
      c_num = chroma * SECTOR_SPAN;
      x_num = chroma * w;
      m_num = (v * UNITY - chroma) * SECTOR_SPAN;
      case (sector)
         SEC_RED: begin
            r_num = c_num; g_num = x_num; b_num = 0;
         end
         SEC_YELLOW: begin
            r_num = x_num; g_num = c_num; b_num = 0;
         end
         SEC_GREEN: begin
            r_num = 0; g_num = c_num; b_num = x_num;
         end
         SEC_CYAN: begin
            r_num = 0; g_num = x_num; b_num = c_num;
         end
         SEC_BLUE: begin
            r_num = x_num; g_num = 0; b_num = c_num;
         end
         default: begin
            r_num = c_num; g_num = 0; b_num = x_num;
         end
      endcase
      lv.red   = scale_level(r_num + m_num);
      lv.green = scale_level(g_num + m_num);
      lv.blue  = scale_level(b_num + m_num);
      return lv;
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("[%0t] %s", $realtime, what);
   endtask

   task automatic check_level(input string chan, input logic [LVL_W-1:0] exp_lvl,
                              input logic [LVL_W-1:0] act_lvl);
      if (act_lvl !== exp_lvl)
         note_failure($sformatf("%s mismatch: expected %0d, got %0d",
                                chan, exp_lvl, act_lvl));
   endtask

   // Scoreboard: compare strobed results first, then log newly accepted beats
   always @(posedge clock) begin
      rgb_levels_type exp_lv;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_levels.size() == 0) begin
               note_failure($sformatf("result with nothing pending: r=%0d g=%0d b=%0d",
                                      rsp_red, rsp_green, rsp_blue));
            end else begin
               exp_lv = expected_levels.pop_front();
               check_level("red",   exp_lv.red,   rsp_red);
               check_level("green", exp_lv.green, rsp_green);
               check_level("blue",  exp_lv.blue,  rsp_blue);
            end
         end
         if (start && !busy)
            expected_levels.push_back(predict_rgb(req_hue, req_saturation,
                                                  req_brightness));
      end
   end

   // Watchdog on cycles with no beat moving either way
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // One beat: random idle cycles, then hold start until accepted
   task automatic send_beat(input logic [HUE_W-1:0] hue, input logic [SV_W-1:0] sat,
                            input logic [SV_W-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Corners of the fields, including over-unity and zero brightness
   task automatic test_extremes();
      send_beat(16'd0,     13'd0,    13'd0);
      send_beat(16'd0,     13'd4096, 13'd4096);
      send_beat(16'd65535, 13'd4096, 13'd4096);
      send_beat(16'd65535, 13'd8191, 13'd8191);
      send_beat(16'd0,     13'd8191, 13'd4096);
      send_beat(16'd320,   13'd4096, 13'd8191);
      send_beat(16'd1234,  13'd4096, 13'd0);
      send_beat(16'd5759,  13'd4096, 13'd4096);
      send_beat(16'd5760,  13'd2048, 13'd4096);
      send_beat(16'd11520, 13'd4095, 13'd4095);
   endtask

   // Both sides of every sector boundary inside the hue turn, 960 to 4800
   task automatic test_sector_edges();
      logic [HUE_W-1:0] edge_hue;
      for (int k = 1; k < 6; k++) begin
         edge_hue = HUE_W'(k * 960);
         send_beat(edge_hue - 16'd1, 13'd4096, 13'd4096);
         send_beat(edge_hue,         13'd3000, 13'd4096);
      end
   endtask

   function automatic logic [SV_W-1:0] pick_fraction();
      int roll;
      roll = $urandom_range(99);
      if (roll < 85) return SV_W'($urandom_range(4096));
      if (roll < 95) return SV_W'($urandom_range(8191, 4097));
      return (roll < 97) ? 13'd0 : 13'd4096;
   endfunction

   // Random colours at a given sender idle rate
   task automatic test_random_stream(input int idle_pct, input int beats);
      sender_idle_pct = idle_pct;
      repeat (beats)
         send_beat(HUE_W'($urandom_range(65535)), pick_fraction(), pick_fraction());
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_hue         = '0;
      req_saturation  = '0;
      req_brightness  = '0;
      sender_idle_pct = 36;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_sector_edges();
      test_random_stream(36, 634);
      test_random_stream(81, 633);
      test_random_stream(0, 633);

      @(negedge clock);
      start <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (expected_levels.size() != 0)
         note_failure("results still pending at end of run");

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
